>>> src/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types, codes and default sizes for the address hash set.
// ----------------------------------------------------------------------------
package ahs_pkg;

   localparam int DEF_INDEX_BITS = 4;
   localparam int DEF_WAYS       = 4;
   localparam int DEF_KEY_BITS   = 64;

   localparam int TYPE_W  = 2;
   localparam int KEY_W   = 64;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   localparam logic [TYPE_W-1:0] OP_ADD   = 2'd0;
   localparam logic [TYPE_W-1:0] OP_DEL   = 2'd1;
   localparam logic [TYPE_W-1:0] OP_CHECK = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXISTS = 2'd1;
   localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic clear_we;
      logic capture;
      logic scan;
      logic commit;
   } ahs_cmd_type;

   typedef struct packed {
      logic out_free;
   } ahs_stat_type;

endpackage

>>> src/ahs_ctrl.sv
// ----------------------------------------------------------------------------
// ahs_ctrl
// Sequencer: clearing pass, item capture, way scan and commit.
// ----------------------------------------------------------------------------
module ahs_ctrl
   import ahs_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   parameter int WAYS       = DEF_WAYS,
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ahs_stat_type          stat,
   output ahs_cmd_type           cmd,
   output logic [INDEX_BITS-1:0] clear_row,
   output logic [WAY_W-1:0]      scan_way,
   output logic [WAY_W-1:0]      rd_way
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

   logic [1:0]            state_ff, state_in;
   logic [INDEX_BITS-1:0] row_ff, row_in;
   logic [WAY_W-1:0]      way_ff, way_in;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      way_in       = way_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rd_way       = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            row_in       = row_ff + INDEX_BITS'(1);
            if (row_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               way_in      = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            rd_way   = way_ff + WAY_W'(1);
            if (way_ff == LAST_WAY) begin
               state_in = S_COMMIT;
            end else begin
               way_in = way_ff + WAY_W'(1);
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign clear_row = row_ff;
   assign scan_way  = way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         row_ff   <= '0;
         way_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         way_ff   <= way_in;
      end
   end

endmodule

>>> src/ahs_datapath.sv
// ----------------------------------------------------------------------------
// ahs_datapath
// Key and valid memories, way compare, count and result register.
// ----------------------------------------------------------------------------
module ahs_datapath
   import ahs_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   parameter int WAYS       = DEF_WAYS,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ahs_cmd_type           cmd,
   output ahs_stat_type          stat,
   input  logic [INDEX_BITS-1:0] clear_row,
   input  logic [WAY_W-1:0]      scan_way,
   input  logic [WAY_W-1:0]      rd_way,
   input  logic [TYPE_W-1:0]     req_type,
   input  logic [KEY_W-1:0]      req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_present,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [COUNT_W-1:0]    rsp_entry_count
);

   localparam int BUCKETS = 1 << INDEX_BITS;
   localparam int ADDR_W  = INDEX_BITS + WAY_W;
   localparam int DEPTH   = 1 << ADDR_W;

   logic [KEY_BITS-1:0]   key_mem [DEPTH];
   logic [WAYS-1:0]       valid_mem [BUCKETS];

   logic [KEY_BITS-1:0]   req_kbits;
   logic [INDEX_BITS-1:0] req_bucket;
   logic [ADDR_W-1:0]     rd_addr;

   logic [TYPE_W-1:0]     op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [INDEX_BITS-1:0] bucket_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [WAYS-1:0]       vrow_ff;
   logic                  hit_ff, hit_in;
   logic [WAY_W-1:0]      hit_way_ff, hit_way_in;
   logic                  free_ff, free_in;
   logic [WAY_W-1:0]      free_way_ff, free_way_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_present_ff;
   logic [STAT_W-1:0]     rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [STAT_W-1:0]     status_c;
   logic [WAYS-1:0]       new_row;
   logic                  key_we;
   logic                  cur_valid;

   assign req_kbits = req_key[KEY_BITS-1:0];

   generate
      if (INDEX_BITS >= KEY_BITS) begin : g_idx_whole
         assign req_bucket = INDEX_BITS'(req_kbits);
      end else begin : g_idx_top
         assign req_bucket = req_kbits[KEY_BITS-1 -: INDEX_BITS];
      end
   endgenerate

   assign rd_addr = cmd.capture ? {req_bucket, rd_way} : {bucket_ff, rd_way};

   // way scan
   assign cur_valid = vrow_ff[scan_way];

   always_comb begin
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      free_in     = free_ff;
      free_way_in = free_way_ff;
      if (cmd.capture) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmd.scan) begin
         if (cur_valid) begin
            if (!hit_ff && key_rd_ff == key_ff) begin
               hit_in     = 1'b1;
               hit_way_in = scan_way;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_way_in = scan_way;
         end
      end
   end

   // commit
   always_comb begin
      status_c = ST_OK;
      new_row  = vrow_ff;
      count_in = count_ff;
      key_we   = 1'b0;
      if (op_ff == OP_ADD) begin
         if (hit_ff) begin
            status_c = ST_EXISTS;
         end else if (!free_ff) begin
            status_c = ST_FULL;
         end else begin
            key_we                = cmd.commit;
            new_row[free_way_ff]  = 1'b1;
            count_in              = count_ff + COUNT_W'(1);
         end
      end else if (op_ff == OP_DEL) begin
         if (hit_ff) begin
            new_row[hit_way_ff] = 1'b0;
            count_in            = count_ff - COUNT_W'(1);
         end else begin
            status_c = ST_ABSENT;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[rd_addr];
      if (key_we) begin
         key_mem[{bucket_ff, free_way_ff}] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vrow_ff <= valid_mem[req_bucket];
      end
      if (cmd.clear_we) begin
         valid_mem[clear_row] <= '0;
      end else if (cmd.commit) begin
         valid_mem[bucket_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_type;
         key_ff    <= req_kbits;
         bucket_ff <= req_bucket;
      end
      hit_way_ff  <= hit_way_in;
      free_way_ff <= free_way_in;
      if (cmd.commit) begin
         rsp_present_ff <= hit_ff;
         rsp_status_ff  <= status_c;
         rsp_count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
         if (cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_present     = rsp_present_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

>>> src/address_hash_set.sv
// ----------------------------------------------------------------------------
// address_hash_set
// Bucketed set of address keys: add, delete and membership check.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_type, req_key
//  rsp_      out        rsp_valid/rsp_stall  rsp_present, rsp_status, rsp_entry_count
//
// Each item passes through capture, one key memory read per way, and commit.
// The single read port of the key memory sets the scan length.
// After reset a clearing pass zeroes all 2^INDEX_BITS valid rows;
// req_stall is high meanwhile.
// A stalled result holds in the output register; the next item is accepted
// and scanned, and waits at commit until the register is free.
// ----------------------------------------------------------------------------
module address_hash_set
   import ahs_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   parameter int WAYS       = DEF_WAYS,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [KEY_W-1:0]   req_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_present,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   ahs_cmd_type           cmd;
   ahs_stat_type          stat;
   logic [INDEX_BITS-1:0] clear_row;
   logic [WAY_W-1:0]      scan_way;
   logic [WAY_W-1:0]      rd_way;

   ahs_ctrl #(
      .INDEX_BITS (INDEX_BITS),
      .WAYS       (WAYS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .clear_row (clear_row),
      .scan_way  (scan_way),
      .rd_way    (rd_way)
   );

   ahs_datapath #(
      .INDEX_BITS (INDEX_BITS),
      .WAYS       (WAYS),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .clear_row       (clear_row),
      .scan_way        (scan_way),
      .rd_way          (rd_way),
      .req_type        (req_type),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_present     (rsp_present),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
